/* rtl/mrrd_pkg.sv */
// ----------------------------------------------------------------------------
// mrrd_pkg
// Shared types, constants and the CRC-16 byte update for the Modbus RTU
// response deframer.
// ----------------------------------------------------------------------------
package mrrd_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
    localparam logic [7:0] FUNC_READ_INPUT   = 8'h04;
    localparam logic [7:0] FUNC_WRITE_MULTI  = 8'h10;

    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_CRC_ERROR   = 2'd1,
        STATUS_UNSUPPORTED = 2'd2,
        STATUS_SHORT       = 2'd3
    } frame_status_t;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 40;

    // One received byte folded into the running CRC, all eight shifts unrolled.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data_in);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data_in};
        for (int k = 0; k < 8; k++)
        begin
            if (crc[0])
            begin
                crc = (crc >> 1) ^ CRC_POLY;
            end
            else
            begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

/* rtl/modbus_rtu_response_deframer.sv */
// ----------------------------------------------------------------------------
// Modbus RTU response deframer
// Parses received response bytes, streams the payload bytes out and reports
// an end-of-frame status after checking the CRC-16.
// ----------------------------------------------------------------------------
//
// Channel   Dir   tdata                                      tuser
// s_axis    in    [7:0] rx_byte                              [0] operation
// m_axis    out   [7:0] data_byte, [15:8] data_index,        [0] is_status
//                 [23:16] device_address,
//                 [31:24] function_code, [33:32] frame_status
//
// Every item passes an input register, and each result it gives a result
// register; one item per cycle is sustained while m_axis is not stalled. The
// CRC update for one byte is unrolled and lies between those two registers.
// rst_n clears the parser state; the held address and function read as zero.
// A stalled m_axis holds the result register, and the input register then
// fills and drops s_axis_tready.
//
module modbus_rtu_response_deframer
    import mrrd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic                  s_axis_tuser,   // [0] operation
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [7:0] data_byte, [15:8] data_index,
                                                  // [23:16] device_address,
                                                  // [31:24] function_code,
                                                  // [33:32] frame_status
    output logic                  m_axis_tuser    // [0] is_status
);

    // Input register.
    logic       in_valid_reg;
    logic       in_op_reg;
    logic [7:0] in_byte_reg;

    // Parser state.
    logic [8:0]  pos_reg, pos_next;
    logic [7:0]  addr_reg, addr_next;
    logic [7:0]  func_reg, func_next;
    logic [7:0]  count_reg, count_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_lo_reg, crc_lo_next;

    // Result register.
    logic          out_valid_reg;
    logic          out_status_reg, out_status_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic [7:0]    out_index_reg, out_index_next;
    logic [7:0]    out_addr_reg, out_addr_next;
    logic [7:0]    out_func_reg, out_func_next;
    frame_status_t out_fs_reg, out_fs_next;
    logic          produce;

    logic        advance;
    logic [15:0] crc_upd;
    logic [8:0]  crc_lo_pos;
    logic [8:0]  data_start;
    logic [8:0]  pos_inc;
    logic [8:0]  index_full;
    logic        func_known;
    logic        func_block;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign crc_upd    = crc16_byte(crc_reg, in_byte_reg);
    assign pos_inc    = pos_reg + 9'd1;
    assign func_block = (func_reg == FUNC_READ_HOLDING) || (func_reg == FUNC_READ_INPUT);
    assign func_known = func_block || (func_reg == FUNC_WRITE_MULTI);
    assign data_start = func_block ? 9'd3 : 9'd2;
    assign crc_lo_pos = func_block ? (9'd3 + {1'b0, count_reg}) : 9'd6;
    assign index_full = pos_reg - data_start;

    always_comb
    begin
        pos_next        = pos_reg;
        addr_next       = addr_reg;
        func_next       = func_reg;
        count_next      = count_reg;
        crc_next        = crc_reg;
        crc_lo_next     = crc_lo_reg;
        produce         = 1'b0;
        out_status_next = 1'b1;
        out_byte_next   = 8'h00;
        out_index_next  = 8'h00;
        out_addr_next   = addr_reg;
        out_func_next   = func_reg;
        out_fs_next     = STATUS_OK;

        priority if (in_op_reg == OP_TIMEOUT)
        begin
            // A timeout between frames is ignored.
            if (pos_reg != 9'd0)
            begin
                produce     = 1'b1;
                out_fs_next = STATUS_SHORT;
                pos_next    = 9'd0;
                crc_next    = CRC_INIT;
                crc_lo_next = 8'h00;
            end
        end
        else if (pos_reg == 9'd0)
        begin
            addr_next  = in_byte_reg;
            func_next  = 8'h00;
            count_next = 8'h00;
            crc_next   = crc16_byte(CRC_INIT, in_byte_reg);
            pos_next   = 9'd1;
        end
        else if (pos_reg == 9'd1)
        begin
            func_next = in_byte_reg;
            crc_next  = crc_upd;
            pos_next  = 9'd2;
        end
        else if (pos_reg == 9'd2 && !(func_reg == FUNC_WRITE_MULTI))
        begin
            // Byte count for block reads; a byte swallowed for unknown functions.
            if (func_block)
            begin
                count_next = in_byte_reg;
            end
            crc_next = crc_upd;
            pos_next = 9'd3;
        end
        else if (!func_known)
        begin
            produce     = 1'b1;
            out_fs_next = STATUS_UNSUPPORTED;
            pos_next    = 9'd0;
            crc_next    = CRC_INIT;
            crc_lo_next = 8'h00;
        end
        else if (pos_reg < crc_lo_pos)
        begin
            produce         = 1'b1;
            out_status_next = 1'b0;
            out_byte_next   = in_byte_reg;
            out_index_next  = index_full[7:0];
            crc_next        = crc_upd;
            pos_next        = pos_inc;
        end
        else if (pos_reg == crc_lo_pos)
        begin
            crc_lo_next = in_byte_reg;
            pos_next    = pos_inc;
        end
        else
        begin
            produce     = 1'b1;
            out_fs_next = ({in_byte_reg, crc_lo_reg} == crc_reg) ? STATUS_OK
                                                                 : STATUS_CRC_ERROR;
            pos_next    = 9'd0;
            crc_next    = CRC_INIT;
            crc_lo_next = 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= 9'd0;
            addr_reg      <= 8'h00;
            func_reg      <= 8'h00;
            count_reg     <= 8'h00;
            crc_reg       <= CRC_INIT;
            crc_lo_reg    <= 8'h00;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= produce;
                pos_reg       <= pos_next;
                addr_reg      <= addr_next;
                func_reg      <= func_next;
                count_reg     <= count_next;
                crc_reg       <= crc_next;
                crc_lo_reg    <= crc_lo_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_op_reg   <= s_axis_tuser;
            in_byte_reg <= s_axis_tdata;
        end
        if (advance && produce)
        begin
            out_status_reg <= out_status_next;
            out_byte_reg   <= out_byte_next;
            out_index_reg  <= out_index_next;
            out_addr_reg   <= out_addr_next;
            out_func_reg   <= out_func_next;
            out_fs_reg     <= out_fs_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {6'b000000, out_fs_reg, out_func_reg, out_addr_reg,
                            out_index_reg, out_byte_reg};

endmodule

/* rtl/mrrd_checker.sv */
// ----------------------------------------------------------------------------
// mrrd_checker
// Port-level checks for the Modbus RTU response deframer.
// ----------------------------------------------------------------------------
module mrrd_checker
    import mrrd_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tuser
);

    // A result waiting on a stalled consumer must not change.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // With no result waiting, the block always takes a new item.
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input not ready while the result side is empty");

    // Data items carry no status code.
    a_data_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[33:32] == STATUS_OK)
        else $error("data item with nonzero status");

    // Payload only comes from supported functions.
    a_data_func: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            m_axis_tdata[31:24] == FUNC_READ_HOLDING ||
            m_axis_tdata[31:24] == FUNC_READ_INPUT ||
            m_axis_tdata[31:24] == FUNC_WRITE_MULTI)
        else $error("data item from unsupported function");

    // An unsupported-function status never names a supported function.
    a_unsup_func: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser && m_axis_tdata[33:32] == STATUS_UNSUPPORTED |->
            m_axis_tdata[31:24] != FUNC_READ_HOLDING &&
            m_axis_tdata[31:24] != FUNC_READ_INPUT &&
            m_axis_tdata[31:24] != FUNC_WRITE_MULTI)
        else $error("unsupported status for a supported function");

endmodule

bind modbus_rtu_response_deframer mrrd_checker u_mrrd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

/* bench/tb_modbus_rtu_response_deframer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for modbus_rtu_response_deframer
// Drives whole, corrupted, truncated and unsupported Modbus RTU response
// frames plus line noise and receive timeouts into the deframer. It keeps its
// own frame parser and CRC-16 to predict every payload byte and end-of-frame
// status, and checks each result field by field, under random back-pressure but in the steady stream test.
// ----------------------------------------------------------------------------
module tb_modbus_rtu_response_deframer;
    import mrrd_pkg::*;

    localparam int RANDOM_ITEMS = 250;
    localparam int STEADY_FRAMES = 25;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic          is_status;
        logic [7:0]    data_byte;
        logic [7:0]    data_index;
        logic [7:0]    device_address;
        logic [7:0]    function_code;
        frame_status_t frame_status;
    } frame_result_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // [7:0] rx_byte
    logic                  s_axis_tuser = OP_BYTE;   // [0] operation
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // [7:0] data_byte, [15:8] data_index,
                                           // [23:16] device_address,
                                           // [31:24] function_code,
                                           // [33:32] frame_status
    logic                  m_axis_tuser;   // [0] is_status

    // Parser state mirrored by the testbench.
    logic [8:0]  frame_pos = '0;
    logic [7:0]  frame_addr = '0;
    logic [7:0]  frame_func = '0;
    logic [7:0]  byte_count = '0;
    logic [15:0] crc_acc = CRC_INIT;
    logic [7:0]  crc_low = '0;

    frame_result_t frame_results_q[$];
    frame_result_t want;

    int  error_count = 0;
    int  sent_count = 0;
    int  cycle_count = 0;
    int  stall_left = 0;
    bit  src_idle_on = 1'b1;
    bit  sink_stall_on = 1'b1;

    modbus_rtu_response_deframer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL modbus_rtu_response_deframer");
            $finish;
        end
    end

    // Reflected CRC-16 with the Modbus polynomial, one byte at a time.
    function automatic logic [15:0] crc16_step(input logic [15:0] crc_in,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = {1'b0, c[15:1]} ^ (c[0] ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    function automatic logic [7:0] pick_supported_func();
        case ($urandom_range(0, 2))
            0:       return FUNC_READ_HOLDING;
            1:       return FUNC_READ_INPUT;
            default: return FUNC_WRITE_MULTI;
        endcase
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v)
        begin
            report_error($sformatf("%s expected %0d got %0d", name, exp_v, got_v));
        end
    endtask

    // Queues the end-of-frame status and rewinds the parser for the next frame.
    task automatic close_frame(input frame_status_t st);
        frame_result_t r;
        r.is_status      = 1'b1;
        r.data_byte      = 8'h00;
        r.data_index     = 8'h00;
        r.device_address = frame_addr;
        r.function_code  = frame_func;
        r.frame_status   = st;
        frame_results_q.push_back(r);
        frame_pos = 9'd0;
        crc_acc   = CRC_INIT;
        crc_low   = 8'h00;
    endtask

    task automatic parse_rx_item(input logic op, input logic [7:0] b);
        logic [8:0]    data_start;
        logic [8:0]    crc_lo_pos;
        logic [8:0]    offset;
        logic          in_body;
        frame_result_t r;
        in_body    = 1'b0;
        data_start = 9'd0;
        crc_lo_pos = 9'd0;
        if (op == OP_TIMEOUT)
        begin
            // A timeout between frames is silent.
            if (frame_pos != 9'd0)
            begin
                close_frame(STATUS_SHORT);
            end
        end
        else if (frame_pos == 9'd0)
        begin
            frame_addr = b;
            frame_func = 8'h00;
            byte_count = 8'h00;
            crc_acc    = crc16_step(CRC_INIT, b);
            frame_pos  = 9'd1;
        end
        else if (frame_pos == 9'd1)
        begin
            frame_func = b;
            crc_acc    = crc16_step(crc_acc, b);
            frame_pos  = 9'd2;
        end
        else if (frame_func == FUNC_WRITE_MULTI)
        begin
            data_start = 9'd2;
            crc_lo_pos = 9'd6;
            in_body    = 1'b1;
        end
        else if (frame_func == FUNC_READ_HOLDING || frame_func == FUNC_READ_INPUT)
        begin
            if (frame_pos == 9'd2)
            begin
                byte_count = b;
                crc_acc    = crc16_step(crc_acc, b);
                frame_pos  = 9'd3;
            end
            else
            begin
                data_start = 9'd3;
                crc_lo_pos = 9'd3 + {1'b0, byte_count};
                in_body    = 1'b1;
            end
        end
        else if (frame_pos == 9'd2)
        begin
            crc_acc   = crc16_step(crc_acc, b);
            frame_pos = 9'd3;
        end
        else
        begin
            close_frame(STATUS_UNSUPPORTED);
        end

        if (in_body)
        begin
            if (frame_pos < crc_lo_pos)
            begin
                offset           = frame_pos - data_start;
                r.is_status      = 1'b0;
                r.data_byte      = b;
                r.data_index     = offset[7:0];
                r.device_address = frame_addr;
                r.function_code  = frame_func;
                r.frame_status   = STATUS_OK;
                frame_results_q.push_back(r);
                crc_acc   = crc16_step(crc_acc, b);
                frame_pos = frame_pos + 9'd1;
            end
            else if (frame_pos == crc_lo_pos)
            begin
                crc_low   = b;
                frame_pos = frame_pos + 9'd1;
            end
            else if ({b, crc_low} == crc_acc)
            begin
                close_frame(STATUS_OK);
            end
            else
            begin
                close_frame(STATUS_CRC_ERROR);
            end
        end
    endtask

    // Called just after a rising edge; returns at the edge that accepts the item.
    task automatic send_item(input logic op, input logic [7:0] b);
        if (src_idle_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        if (op == OP_BYTE || frame_pos != 9'd0)
        begin
            sent_count++;
        end
        parse_rx_item(op, b);
    endtask

    // fill < 0 gives random payload bytes. cut_at >= 0 stops after that many
    // bytes and ends the frame with a timeout; -2 picks the cut at random.
    task automatic send_frame(input logic [7:0] addr, input logic [7:0] func,
                              input int n_data, input int fill, input bit bad_crc,
                              input int cut_at);
        logic [7:0]  frame_bytes[$];
        logic [15:0] crc;
        logic [15:0] flip;
        logic [7:0]  d;
        int          n;
        int          cut;
        frame_bytes.push_back(addr);
        frame_bytes.push_back(func);
        if (func == FUNC_WRITE_MULTI)
        begin
            n = 4;
        end
        else if (func == FUNC_READ_HOLDING || func == FUNC_READ_INPUT)
        begin
            n = n_data;
            frame_bytes.push_back(n_data[7:0]);
        end
        else
        begin
            n = 2;
        end
        for (int i = 0; i < n; i++)
        begin
            d = (fill < 0) ? 8'($urandom_range(0, 255)) : fill[7:0];
            frame_bytes.push_back(d);
        end
        // Unsupported functions end on their fourth byte and carry no CRC.
        if (func == FUNC_WRITE_MULTI || func == FUNC_READ_HOLDING ||
            func == FUNC_READ_INPUT)
        begin
            crc = CRC_INIT;
            foreach (frame_bytes[i])
            begin
                crc = crc16_step(crc, frame_bytes[i]);
            end
            flip = bad_crc ? 16'($urandom_range(1, 65535)) : 16'h0000;
            crc  = crc ^ flip;
            frame_bytes.push_back(crc[7:0]);
            frame_bytes.push_back(crc[15:8]);
        end
        cut = (cut_at == -2) ? $urandom_range(1, frame_bytes.size() - 1) : cut_at;
        foreach (frame_bytes[i])
        begin
            if (cut >= 0 && i >= cut)
            begin
                break;
            end
            send_item(OP_BYTE, frame_bytes[i]);
        end
        if (cut >= 0)
        begin
            send_item(OP_TIMEOUT, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        while (frame_results_q.size() != 0) @(posedge clk);
    endtask

    task automatic test_directed_frames();
        // Timeout on an idle line, then one frame of every kind and outcome.
        send_item(OP_TIMEOUT, 8'hFF);
        send_frame(8'h00, FUNC_WRITE_MULTI, 4, 8'h00, 1'b0, -1);
        send_frame(8'hFF, FUNC_READ_HOLDING, 1, 8'hFF, 1'b1, -1);
        send_frame(8'h81, FUNC_READ_INPUT, 0, -1, 1'b0, -1);
        send_frame(8'h5A, 8'hFF, 0, -1, 1'b0, -1);
        send_frame(8'h7E, FUNC_READ_HOLDING, 3, -1, 1'b0, 1);
    endtask

    task automatic test_drain_pause();
        send_frame(8'h11, FUNC_READ_HOLDING, 6, -1, 1'b0, -1);
        wait_for_drain();
        send_frame(8'h22, FUNC_WRITE_MULTI, 4, -1, 1'b0, -1);
    endtask

    task automatic test_random_traffic();
        int         start_count;
        int         kind;
        int         n;
        int         noise_len;
        logic [7:0] fn;
        src_idle_on   = 1'b1;
        sink_stall_on = 1'b1;
        start_count   = sent_count;
        while (sent_count - start_count < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 9);
            fn   = pick_supported_func();
            // Long payloads are rare so that most frames stay short.
            n = ($urandom_range(0, 49) == 0) ? $urandom_range(200, 255)
                                              : $urandom_range(0, 8);
            if (kind <= 5)
            begin
                send_frame(8'($urandom_range(0, 255)), fn, n, -1,
                           $urandom_range(0, 5) == 0, -1);
            end
            else if (kind == 6)
            begin
                do
                begin
                    fn = 8'($urandom_range(0, 255));
                end
                while (fn == FUNC_READ_HOLDING || fn == FUNC_READ_INPUT ||
                       fn == FUNC_WRITE_MULTI);
                send_frame(8'($urandom_range(0, 255)), fn, 0, -1, 1'b0, -1);
            end
            else if (kind == 7)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    fn = 8'($urandom_range(0, 255));
                end
                send_frame(8'($urandom_range(0, 255)), fn, n, -1, 1'b0, -2);
            end
            else
            begin
                // Line noise, then a timeout so the next frame starts clean.
                noise_len = $urandom_range(1, 6);
                for (int i = 0; i < noise_len; i++)
                begin
                    send_item(($urandom_range(0, 3) == 0) ? OP_TIMEOUT : OP_BYTE,
                              8'($urandom_range(0, 255)));
                end
                send_item(OP_TIMEOUT, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic test_steady_stream();
        src_idle_on   = 1'b0;
        sink_stall_on = 1'b0;
        for (int i = 0; i < STEADY_FRAMES; i++)
        begin
            send_frame(8'($urandom_range(0, 255)), pick_supported_func(),
                       $urandom_range(0, 8), -1, $urandom_range(0, 4) == 0, -1);
        end
    endtask

    // Result sink with random stall bursts.
    always @(posedge clk)
    begin
        if (sink_stall_on && stall_left == 0 && $urandom_range(0, 3) == 0)
        begin
            stall_left = $urandom_range(1, 4);
        end
        if (sink_stall_on && stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            stall_left = 0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (frame_results_q.size() == 0)
            begin
                report_error($sformatf("unexpected item tuser=%0d tdata=%h",
                                       m_axis_tuser, m_axis_tdata));
            end
            else
            begin
                want = frame_results_q.pop_front();
                check_field("is_status", want.is_status, m_axis_tuser);
                check_field("data_byte", want.data_byte, m_axis_tdata[7:0]);
                check_field("data_index", want.data_index, m_axis_tdata[15:8]);
                check_field("device_address", want.device_address,
                            m_axis_tdata[23:16]);
                check_field("function_code", want.function_code, m_axis_tdata[31:24]);
                check_field("frame_status", want.frame_status, m_axis_tdata[33:32]);
            end
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_frames();
        test_drain_pause();
        test_random_traffic();
        test_steady_stream();
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("PASS modbus_rtu_response_deframer");
        end
        else
        begin
            $display("FAIL modbus_rtu_response_deframer");
        end
        $finish;
    end

endmodule
